// File: design/smsd_pkg.sv
// shared types and defaults for the sample mean and standard deviation block
`default_nettype none

package smsd_pkg;

  localparam int MAX_LEN_DEFAULT      = 1024;
  localparam int SAMPLE_WIDTH_DEFAULT = 24;

  // fixed field widths of the item formats
  localparam int SAMPLE_BITS = 24;
  localparam int COUNT_BITS  = 11;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          last;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] mean_value;
    logic [SAMPLE_BITS-1:0]        std_dev;
    logic [COUNT_BITS-1:0]         element_total;
    logic                          overflow;
  } out_item_t;

  // accumulator control from the front end and the back end sequencer
  typedef struct packed {
    logic take;
    logic clear;
  } acc_ctl_t;

endpackage

`default_nettype wire

// File: design/smsd_accum.sv
// running count, sum and sum of squares of the samples of one vector
`default_nettype none

module smsd_accum
  import smsd_pkg::*;
#(
  parameter int  MAX_LEN      = MAX_LEN_DEFAULT,
  parameter int  SAMPLE_WIDTH = SAMPLE_WIDTH_DEFAULT,
  localparam int CW           = $clog2(MAX_LEN + 1),
  localparam int SUMW         = SAMPLE_WIDTH + CW,
  localparam int SQW          = 2 * SAMPLE_WIDTH + CW - 1
) (
  input  logic                          clk,
  input  logic                          rst,
  input  acc_ctl_t                      ctl,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  output logic [CW-1:0]                 count,
  output logic signed [SUMW-1:0]        sum,
  output logic [SQW-1:0]                sum_sq,
  output logic                          overflow_seen
);

  logic signed [SAMPLE_WIDTH-1:0]   x;
  logic signed [2*SAMPLE_WIDTH-1:0] sq;
  logic                             full;

  // upper sample bits are ignored
  assign x    = sample[SAMPLE_WIDTH-1:0];
  assign sq   = x * x;
  assign full = (count == CW'(MAX_LEN));

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      count         <= '0;
      sum           <= '0;
      sum_sq        <= '0;
      overflow_seen <= 1'b0;
    end else if (ctl.take) begin
      if (!full) begin
        count  <= count + 1'b1;
        sum    <= sum + SUMW'(x);
        sum_sq <= sum_sq + SQW'(sq);
      end else begin
        overflow_seen <= 1'b1;
      end
    end
  end

  a_full_sets_overflow: assert property (@(posedge clk) disable iff (rst)
    ctl.take && !ctl.clear && full |=> overflow_seen)
    else $error("extra sample did not flag overflow");

  a_count_steps: assert property (@(posedge clk) disable iff (rst)
    ctl.take && !ctl.clear && !full |=> count == $past(count) + 1'b1)
    else $error("count did not advance on an accepted sample");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    ctl.clear |=> count == '0 && sum == '0 && sum_sq == '0 && !overflow_seen)
    else $error("accumulators not cleared");

endmodule

`default_nettype wire

// File: design/smsd_alu.sv
// shared add / subtract unit of the back end
`default_nettype none

module smsd_alu #(
  parameter int AW = 8
) (
  input  logic [AW-1:0] a,
  input  logic [AW-1:0] b,
  input  logic          sub,
  output logic [AW-1:0] y
);

  assign y = a + (sub ? ~b : b) + AW'(sub);

endmodule

`default_nettype wire

// File: design/smsd_engine.sv
// back end sequencer: mean, variance and square root on one shared adder
`default_nettype none

module smsd_engine
  import smsd_pkg::*;
#(
  parameter int  MAX_LEN      = MAX_LEN_DEFAULT,
  parameter int  SAMPLE_WIDTH = SAMPLE_WIDTH_DEFAULT,
  localparam int CW           = $clog2(MAX_LEN + 1),
  localparam int SUMW         = SAMPLE_WIDTH + CW,
  localparam int SQW          = 2 * SAMPLE_WIDTH + CW - 1
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [CW-1:0]          count,
  input  logic signed [SUMW-1:0] sum,
  input  logic [SQW-1:0]         sum_sq,
  input  logic                   overflow_seen,
  output logic                   busy,
  output logic                   clear,
  output logic                   out_valid,
  input  logic                   out_ready,
  output out_item_t              out_data
);

  localparam int SW   = SAMPLE_WIDTH;
  localparam int MAGW = SW + CW - 1;
  localparam int W    = 2 * SW + 2 * CW - 1;
  localparam int AW   = W + 1;
  localparam int RMW  = (2 * CW + 1 > SW + 3) ? 2 * CW + 1 : SW + 3;
  localparam int CNTW = $clog2(W + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_LOAD, S_MUL1, S_MUL2, S_SUB, S_DMUL, S_DIV, S_SQRT, S_MEAN, S_DONE
  } state_t;

  state_t          state, state_next;
  logic [CNTW-1:0] cnt, cnt_next;
  logic [CW-1:0]   n, n_next, nm1;
  logic            neg, neg_next;
  logic [MAGW-1:0] mag, mag_next;
  logic [SQW-1:0]  s2, s2_next;
  logic            ovf, ovf_next;
  logic [W-1:0]    acc, acc_next;
  logic [W-1:0]    prod, prod_next;
  logic [MAGW-1:0] mq, mq_next;
  logic [RMW-1:0]  rem, rem_next;
  logic [SW-1:0]   root, root_next;
  logic            out_valid_next;
  out_item_t       out_data_next;

  logic [AW-1:0]     alu_a, alu_b, alu_y;
  logic              alu_sub, ok, last_step;
  logic [RMW-1:0]    rsh_div, rsh_mean, rsh_sq;
  logic signed [MAGW:0] mean_s;

  smsd_alu #(.AW(AW)) u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .sub (alu_sub),
    .y   (alu_y)
  );

  assign ok        = !alu_y[AW-1];
  assign last_step = (cnt == CNTW'(1));
  assign nm1       = n - 1'b1;
  assign rsh_div   = {rem[RMW-2:0], acc[W-1]};
  assign rsh_mean  = {rem[RMW-2:0], mq[MAGW-1]};
  assign rsh_sq    = {rem[RMW-3:0], acc[W-1:W-2]};
  assign mean_s    = alu_y[MAGW:0];
  assign busy      = (state != S_IDLE);

  always_comb begin
    state_next     = state;
    cnt_next       = cnt;
    n_next         = n;
    neg_next       = neg;
    mag_next       = mag;
    s2_next        = s2;
    ovf_next       = ovf;
    acc_next       = acc;
    prod_next      = prod;
    mq_next        = mq;
    rem_next       = rem;
    root_next      = root;
    out_valid_next = out_valid && !out_ready;
    out_data_next  = out_data;
    alu_a          = '0;
    alu_b          = '0;
    alu_sub        = 1'b0;
    clear          = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (start) state_next = S_LOAD;
      end
      S_LOAD: begin
        // magnitude of the sum
        alu_b     = AW'(sum);
        alu_sub   = sum[SUMW-1];
        n_next    = count;
        neg_next  = sum[SUMW-1];
        mag_next  = alu_y[MAGW-1:0];
        s2_next   = sum_sq;
        ovf_next  = overflow_seen;
        acc_next  = '0;
        rem_next  = '0;
        root_next = '0;
        if (count < CW'(2)) begin
          mq_next    = alu_y[MAGW-1:0];
          cnt_next   = CNTW'(MAGW);
          state_next = S_MEAN;
        end else begin
          mq_next    = MAGW'(count) << (MAGW - CW);
          cnt_next   = CNTW'(CW);
          state_next = S_MUL1;
        end
      end
      S_MUL1: begin
        // n * sum of squares, msb first
        alu_a    = AW'(acc) << 1;
        alu_b    = mq[MAGW-1] ? AW'(s2) : '0;
        acc_next = alu_y[W-1:0];
        mq_next  = mq << 1;
        cnt_next = cnt - 1'b1;
        if (last_step) begin
          prod_next  = alu_y[W-1:0];
          acc_next   = '0;
          mq_next    = mag;
          cnt_next   = CNTW'(MAGW);
          state_next = S_MUL2;
        end
      end
      S_MUL2: begin
        // sum squared
        alu_a    = AW'(acc) << 1;
        alu_b    = mq[MAGW-1] ? AW'(mag) : '0;
        acc_next = alu_y[W-1:0];
        mq_next  = mq << 1;
        cnt_next = cnt - 1'b1;
        if (last_step) state_next = S_SUB;
      end
      S_SUB: begin
        alu_a      = AW'(prod);
        alu_b      = AW'(acc);
        alu_sub    = 1'b1;
        acc_next   = alu_y[W-1:0];
        prod_next  = '0;
        mq_next    = MAGW'(n) << (MAGW - CW);
        cnt_next   = CNTW'(CW);
        state_next = S_DMUL;
      end
      S_DMUL: begin
        // divisor n * (n - 1)
        alu_a     = AW'(prod) << 1;
        alu_b     = mq[MAGW-1] ? AW'(nm1) : '0;
        prod_next = alu_y[W-1:0];
        mq_next   = mq << 1;
        cnt_next  = cnt - 1'b1;
        if (last_step) begin
          rem_next   = '0;
          cnt_next   = CNTW'(W);
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        // restoring division, quotient shifts into acc
        alu_a    = AW'(rsh_div);
        alu_b    = AW'(prod);
        alu_sub  = 1'b1;
        rem_next = ok ? alu_y[RMW-1:0] : rsh_div;
        acc_next = {acc[W-2:0], ok};
        cnt_next = cnt - 1'b1;
        if (last_step) begin
          // align the variance to the top for two bits a step
          acc_next   = {acc[W-2:0], ok} << (W - 2 * SW);
          rem_next   = '0;
          root_next  = '0;
          cnt_next   = CNTW'(SW);
          state_next = S_SQRT;
        end
      end
      S_SQRT: begin
        alu_a     = AW'(rsh_sq);
        alu_b     = AW'({root, 2'b01});
        alu_sub   = 1'b1;
        rem_next  = ok ? alu_y[RMW-1:0] : rsh_sq;
        root_next = {root[SW-2:0], ok};
        acc_next  = acc << 2;
        cnt_next  = cnt - 1'b1;
        if (last_step) begin
          mq_next    = mag;
          rem_next   = '0;
          cnt_next   = CNTW'(MAGW);
          state_next = S_MEAN;
        end
      end
      S_MEAN: begin
        // |sum| / n, quotient shifts into mq
        alu_a    = AW'(rsh_mean);
        alu_b    = AW'(n);
        alu_sub  = 1'b1;
        rem_next = ok ? alu_y[RMW-1:0] : rsh_mean;
        mq_next  = {mq[MAGW-2:0], ok};
        cnt_next = cnt - 1'b1;
        if (last_step) state_next = S_DONE;
      end
      S_DONE: begin
        // restore the sign of the mean
        alu_b   = AW'(mq);
        alu_sub = neg;
        if (!out_valid || out_ready) begin
          out_valid_next              = 1'b1;
          out_data_next.mean_value    = SAMPLE_BITS'(mean_s);
          out_data_next.std_dev       = SAMPLE_BITS'(root);
          out_data_next.element_total = COUNT_BITS'(n);
          out_data_next.overflow      = ovf;
          clear                       = 1'b1;
          state_next                  = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      out_valid <= out_valid_next;
    end
    n        <= n_next;
    neg      <= neg_next;
    mag      <= mag_next;
    s2       <= s2_next;
    ovf      <= ovf_next;
    acc      <= acc_next;
    prod     <= prod_next;
    mq       <= mq_next;
    rem      <= rem_next;
    root     <= root_next;
    out_data <= out_data_next;
  end

  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> rem < prod)
    else $error("division remainder not below divisor");

  a_sqrt_rem: assert property (@(posedge clk) disable iff (rst)
    state == S_SQRT |-> rem <= {root, 1'b0})
    else $error("root remainder above twice the root");

  a_mean_rem: assert property (@(posedge clk) disable iff (rst)
    state == S_MEAN |-> rem < n)
    else $error("mean remainder not below count");

  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    state == S_DONE && out_valid && !out_ready |=> state == S_DONE)
    else $error("pending result overwritten");

endmodule

`default_nettype wire

// File: design/sample_mean_and_std_dev.sv
// top level: streamed sample mean and sample standard deviation
`default_nettype none

// channel  signals                          item
// -------  -------------------------------  -----------------------------------------
// in       in_valid, in_ready, in_data      one sample and its last flag
// out      out_valid, out_ready, out_data   mean, std deviation, count, overflow
//
// a sample without last only updates the accumulators; items may follow back to back
// a sample with last starts the back end; its one shared adder steps the multiplies,
// the variance division, the root and the mean division one bit (or bit pair) per cycle
// a vector of one element skips straight to the mean division
// in_ready stays low while the back end runs; a pending result waits in out_data
// reset is synchronous and clears count, sums, overflow flag and the sequencer

module sample_mean_and_std_dev
  import smsd_pkg::*;
#(
  parameter int MAX_LEN      = MAX_LEN_DEFAULT,
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEFAULT
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam int CW   = $clog2(MAX_LEN + 1);
  localparam int SUMW = SAMPLE_WIDTH + CW;
  localparam int SQW  = 2 * SAMPLE_WIDTH + CW - 1;

  acc_ctl_t              ctl;
  logic                  busy;
  logic                  clear;
  logic                  take;
  logic [CW-1:0]         count;
  logic signed [SUMW-1:0] sum;
  logic [SQW-1:0]        sum_sq;
  logic                  overflow_seen;

  // front end takes items whenever the back end is idle
  assign in_ready  = !busy;
  assign take      = in_valid && in_ready;
  assign ctl.take  = take;
  assign ctl.clear = clear;

  // count, sum and sum of squares, one sample per cycle while the back end is idle
  smsd_accum #(
    .MAX_LEN      (MAX_LEN),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_accum (
    .clk           (clk),
    .rst           (rst),
    .ctl           (ctl),
    .sample        (in_data.sample),
    .count         (count),
    .sum           (sum),
    .sum_sq        (sum_sq),
    .overflow_seen (overflow_seen)
  );

  // mean and deviation once per vector, then clear the accumulators
  smsd_engine #(
    .MAX_LEN      (MAX_LEN),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_engine (
    .clk           (clk),
    .rst           (rst),
    .start         (take && in_data.last),
    .count         (count),
    .sum           (sum),
    .sum_sq        (sum_sq),
    .overflow_seen (overflow_seen),
    .busy          (busy),
    .clear         (clear),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data)
  );

endmodule

`default_nettype wire

// File: verif/smsd_stats_checker.sv
// checker for the mean and std deviation block: predicts each vector result and compares
`timescale 1ns / 1ps

module smsd_stats_checker
  import smsd_pkg::*;
#(
  parameter int MAX_LEN      = MAX_LEN_DEFAULT,
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEFAULT
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic      in_ready,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_ready,
  input  out_item_t out_data,
  output int        errors,
  output int        pending,
  output int        vectors_done,
  output int        overflow_vectors
);

  // running statistics of the vector in flight
  int          acc_count    = 0;
  longint      acc_sum      = 0;
  logic [63:0] acc_squares  = '0;
  bit          acc_overflow = 1'b0;

  out_item_t expected_stats[$];
  int        mismatch_total = 0;
  int        results_total  = 0;
  int        overflow_total = 0;

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatch_total++;
  endtask

  // low SAMPLE_WIDTH bits, sign-extended
  function automatic longint sample_value(input logic [SAMPLE_BITS-1:0] raw_in);
    logic [63:0] raw;
    raw = 64'(raw_in) & ((64'd1 << SAMPLE_WIDTH) - 64'd1);
    if (raw[SAMPLE_WIDTH-1])
      return longint'(raw) - (longint'(1) << SAMPLE_WIDTH);
    return longint'(raw);
  endfunction

  function automatic logic [63:0] root_floor(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] trial;
    r = '0;
    for (int b = 31; b >= 0; b--) begin
      trial = r | (64'd1 << b);
      if (trial * trial <= v)
        r = trial;
    end
    return r;
  endfunction

  // mean truncated toward zero, sample deviation with n-1 in the denominator
  function automatic out_item_t summarize(input int n, input longint s1,
                                          input logic [63:0] s2, input bit ovf);
    out_item_t   r;
    logic [63:0] mag;
    logic [63:0] mean_mag;
    logic [63:0] var_q;
    logic [63:0] sd;
    logic [127:0] spread;
    longint      mean;
    mag      = (s1 < 0) ? 64'(-s1) : 64'(s1);
    mean_mag = mag / 64'(n);
    mean     = (s1 < 0) ? -longint'(mean_mag) : longint'(mean_mag);
    if (n < 2) begin
      sd = '0;
    end else begin
      spread = 128'(n) * 128'(s2) - 128'(mag) * 128'(mag);
      var_q  = 64'(spread / 128'(n * (n - 1)));
      sd     = root_floor(var_q);
    end
    r.mean_value    = mean[SAMPLE_BITS-1:0];
    r.std_dev       = sd[SAMPLE_BITS-1:0];
    r.element_total = n[COUNT_BITS-1:0];
    r.overflow      = ovf;
    return r;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    longint    x;
    if (rst) begin
      acc_count    = 0;
      acc_sum      = 0;
      acc_squares  = '0;
      acc_overflow = 1'b0;
      expected_stats.delete();
    end else begin
      if (in_valid && in_ready) begin
        x = sample_value(in_data.sample);
        if (acc_count < MAX_LEN) begin
          acc_count++;
          acc_sum     += x;
          acc_squares += 64'(x * x);
        end else begin
          acc_overflow = 1'b1;
        end
        if (in_data.last) begin
          expected_stats.push_back(summarize(acc_count, acc_sum, acc_squares, acc_overflow));
          acc_count    = 0;
          acc_sum      = 0;
          acc_squares  = '0;
          acc_overflow = 1'b0;
        end
      end
      if (out_valid && out_ready) begin
        results_total++;
        if (expected_stats.size() == 0) begin
          report_mismatch("result arrived with none expected");
        end else begin
          want = expected_stats.pop_front();
          if (want.overflow)
            overflow_total++;
          if (out_data.mean_value != want.mean_value)
            report_mismatch($sformatf("mean_value got %0d expected %0d",
                                      out_data.mean_value, want.mean_value));
          if (out_data.std_dev != want.std_dev)
            report_mismatch($sformatf("std_dev got %0d expected %0d",
                                      out_data.std_dev, want.std_dev));
          if (out_data.element_total != want.element_total)
            report_mismatch($sformatf("element_total got %0d expected %0d",
                                      out_data.element_total, want.element_total));
          if (out_data.overflow != want.overflow)
            report_mismatch($sformatf("overflow got %0b expected %0b",
                                      out_data.overflow, want.overflow));
        end
      end
    end
    errors           <= mismatch_total;
    pending          <= expected_stats.size();
    vectors_done     <= results_total;
    overflow_vectors <= overflow_total;
  end

endmodule

// File: verif/sample_mean_and_std_dev_tb.sv
// testbench top: streams sample vectors into the mean and std deviation block
`timescale 1ns / 1ps

module sample_mean_and_std_dev_tb;
  import smsd_pkg::*;

  localparam int MAX_LEN      = MAX_LEN_DEFAULT;
  localparam int SAMPLE_WIDTH = SAMPLE_WIDTH_DEFAULT;

  // receiver hold-off, end drain and watchdog, all in clock cycles
  // the drain is long enough to cover one more back end pass
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 250;
  localparam int STALL_LIMIT  = 4000;

  localparam logic [SAMPLE_BITS-1:0] MOST_POS  = 24'h7FFFFF;
  localparam logic [SAMPLE_BITS-1:0] MOST_NEG  = 24'h800000;
  localparam logic [SAMPLE_BITS-1:0] MINUS_ONE = 24'hFFFFFF;

  // how the samples of one vector are spread
  typedef enum int {
    SPREAD_FULL,
    SPREAD_EXTREME,
    SPREAD_CLUSTER
  } spread_e;

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  // shared with the receiver process, always written with nonblocking
  logic idle_mode;
  logic hold_req;

  int errors;
  int pending;
  int vectors_done;
  int overflow_vectors;

  int samples_sent   = 0;
  int longest_vector = 0;
  int quiet_cycles   = 0;

  sample_mean_and_std_dev #(
    .MAX_LEN      (MAX_LEN),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  smsd_stats_checker #(
    .MAX_LEN      (MAX_LEN),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) stats_check (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data          (in_data),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_data         (out_data),
    .errors           (errors),
    .pending          (pending),
    .vectors_done     (vectors_done),
    .overflow_vectors (overflow_vectors)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // one sample onto the input channel; valid holds until the block takes it
  task automatic push_sample(input logic [SAMPLE_BITS-1:0] s, input logic is_last);
    // random gap before the item, only while idling is on
    while (idle_mode && $urandom_range(99) < 33) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_data.sample <= s;
    in_data.last   <= is_last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    samples_sent++;
  endtask

  function automatic logic [SAMPLE_BITS-1:0] draw_sample(input spread_e kind,
                                                         input logic [SAMPLE_BITS-1:0] center);
    case (kind)
      SPREAD_FULL: begin
        return SAMPLE_BITS'($urandom);
      end
      SPREAD_EXTREME: begin
        case ($urandom_range(3))
          0:       return MOST_POS;
          1:       return MOST_NEG;
          2:       return '0;
          default: return MINUS_ONE;
        endcase
      end
      // near-equal samples give small deviations and exercise the root low bits
      default: begin
        return center + SAMPLE_BITS'($urandom_range(64)) - SAMPLE_BITS'(32);
      end
    endcase
  endfunction

  task automatic send_vector(input int len, input spread_e kind);
    logic [SAMPLE_BITS-1:0] center;
    center = SAMPLE_BITS'($urandom);
    for (int i = 0; i < len; i++)
      push_sample(draw_sample(kind, center), i == len - 1);
    if (len > longest_vector)
      longest_vector = len;
  endtask

  // mostly short vectors since each multi-sample one costs a full back end pass
  task automatic random_phase(input int quota);
    int      sent_here;
    int      len;
    int      pick;
    spread_e kind;
    sent_here = 0;
    while (sent_here < quota) begin
      pick = $urandom_range(99);
      if (pick < 15)
        len = 1;
      else if (pick < 60)
        len = $urandom_range(2, 8);
      else if (pick < 88)
        len = $urandom_range(9, 40);
      else
        len = $urandom_range(41, 150);
      kind = spread_e'($urandom_range(2));
      send_vector(len, kind);
      sent_here += len;
    end
  endtask

  // receiver: random stalls while idling is on, one long hold-off on request
  initial begin
    out_ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        // hold_req never drops, so the hold-off runs once
        while (hold_req) begin
          out_ready <= (!idle_mode || $urandom_range(99) >= 33);
          @(posedge clk);
        end
      end
      out_ready <= (!idle_mode || $urandom_range(99) >= 33);
    end
  end

  // watchdog: ends the run when neither channel moves for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("timeout: no item moved for %0d cycles, %0d results pending",
                 STALL_LIMIT, pending);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // stimulus and verdict
  initial begin
    rst            <= 1'b1;
    in_valid       <= 1'b0;
    in_data        <= '0;
    idle_mode      <= 1'b1;
    hold_req       <= 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // single-element vectors: deviation must be zero, mean is the sample
    push_sample(MOST_POS, 1'b1);
    push_sample(MOST_NEG, 1'b1);
    push_sample('0, 1'b1);

    // two extremes: sum is -1, mean truncates to zero, widest deviation
    push_sample(MOST_POS, 1'b0);
    push_sample(MOST_NEG, 1'b1);

    // negative mean with a remainder, truncation toward zero
    push_sample(MINUS_ONE, 1'b0);
    push_sample(MINUS_ONE, 1'b0);
    push_sample(24'hFFFFFE, 1'b1);

    // alternating bit patterns and a plain sample of 256
    push_sample(24'h555555, 1'b0);
    push_sample(24'hAAAAAA, 1'b0);
    push_sample(24'h000100, 1'b0);
    push_sample(24'hAAAAAA, 1'b0);
    push_sample(24'h555555, 1'b1);

    // exactly MAX_LEN of the most negative value: largest count and |sum|, no overflow
    for (int i = 0; i < MAX_LEN; i++)
      push_sample(MOST_NEG, i == MAX_LEN - 1);

    // two extra samples past MAX_LEN, the ignored last one carries the last flag
    for (int i = 0; i < MAX_LEN + 2; i++)
      push_sample((i % 2) ? MOST_NEG : MOST_POS, i == MAX_LEN + 1);
    longest_vector = MAX_LEN + 2;

    // receiver holds off while short vectors keep coming: the pending result
    // blocks the back end and the block stalls its input
    hold_req <= 1'b1;
    for (int v = 0; v < 4; v++)
      send_vector($urandom_range(1, 3), SPREAD_FULL);

    // random vectors: idling, a long stretch with none, idling again
    random_phase(250);
    idle_mode <= 1'b0;
    random_phase(150);
    idle_mode <= 1'b1;
    random_phase(200);

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d samples in %0d vectors, %0d of them past the length limit",
             samples_sent, vectors_done, overflow_vectors);
    $display("longest vector %0d samples, one receiver hold-off of %0d cycles",
             longest_vector, HOLD_CYCLES);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
